[rtl/srtf_pkg.sv]
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and constants for the shortest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package srtf_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int DATA_W        = 16;
    localparam int TIME_W        = 24;
    localparam int CNT_W         = 5;
    localparam int NPROC_W       = 5;

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [3:0]        proc_index;
        logic [DATA_W-1:0] arrival;
        logic [DATA_W-1:0] burst;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0] tick_time;
        logic [3:0]        chosen_proc;
        logic              idle;
        logic              finished;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
    } result_t;

    // best candidate held during a scan
    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] arrival;
        logic [DATA_W-1:0] burst;
    } best_t;

endpackage

`default_nettype wire

[rtl/srtf_ram.sv]
// ----------------------------------------------------------------------------
// srtf_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/srtf_select.sv]
// ----------------------------------------------------------------------------
// srtf_select
// Running minimum over scanned table entries, lowest index wins a tie.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_select #(
    parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                clear,
    input  wire logic                                eval,
    input  wire logic [$clog2(MAX_PROCS)-1:0]        idx,
    input  wire logic [srtf_pkg::DATA_W-1:0]         rem,
    input  wire logic [srtf_pkg::DATA_W-1:0]         arrival,
    input  wire logic [srtf_pkg::DATA_W-1:0]         burst,
    input  wire logic [srtf_pkg::TIME_W-1:0]         now,
    output srtf_pkg::best_t                          best,
    output logic      [$clog2(MAX_PROCS)-1:0]        pick
);

    localparam int IDX_W = $clog2(MAX_PROCS);

    srtf_pkg::best_t  best_reg;
    srtf_pkg::best_t  best_next;
    logic [IDX_W-1:0] pick_reg;
    logic [IDX_W-1:0] pick_next;
    logic             ready;
    logic             take;

    assign ready = (rem != '0) &&
                   (srtf_pkg::TIME_W'(arrival) <= now);
    // strict less-than keeps the earlier index on equal remaining time
    assign take  = eval && ready && (!best_reg.found || rem < best_reg.rem);

    always_comb
    begin
        best_next = best_reg;
        pick_next = pick_reg;
        if (clear)
        begin
            best_next.found = 1'b0;
        end
        else if (take)
        begin
            best_next.found   = 1'b1;
            best_next.rem     = rem;
            best_next.arrival = arrival;
            best_next.burst   = burst;
            pick_next         = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
            pick_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
            pick_reg <= pick_next;
        end
    end

    assign best = best_reg;
    assign pick = pick_reg;

endmodule

`default_nettype wire

[rtl/srtf_scheduler.sv]
// ----------------------------------------------------------------------------
// srtf_scheduler
// Preemptive shortest-remaining-time-first scheduler with table in RAM.
// ----------------------------------------------------------------------------
// load word: accepted with busy low, written in the accept cycle, no result;
//   a new word can follow in every cycle
// tick word: busy through the scan, calc and report states, result strobe in the
//   same cycle that busy falls; the scan reads one table entry per cycle from RAM
// result_valid is a one-cycle strobe, the receiver cannot stall it
// reset: time, completion count, num_procs and all remaining times read zero
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_scheduler #(
    parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire srtf_pkg::item_t                item,
    output srtf_pkg::result_t                   result,
    output logic                                result_valid,
    input  wire logic                           cfg_we,
    input  wire logic [srtf_pkg::NPROC_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int NW    = (CNT_W > srtf_pkg::NPROC_W) ? CNT_W : srtf_pkg::NPROC_W;
    localparam int AB_W  = 2 * srtf_pkg::DATA_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_REPORT
    } state_t;

    state_t                           state_reg;
    logic [srtf_pkg::NPROC_W-1:0]     num_procs_reg;
    logic [srtf_pkg::TIME_W-1:0]      time_reg;
    logic [srtf_pkg::CNT_W-1:0]       done_cnt_reg;
    logic [MAX_PROCS-1:0]             valid_reg;
    logic [CNT_W-1:0]                 scan_cnt_reg;
    logic                             pend_reg;
    logic [IDX_W-1:0]                 rd_idx_reg;
    logic                             rd_valid_reg;
    srtf_pkg::result_t                result_reg;
    logic                             result_valid_reg;

    logic                             accept;
    logic                             load_acc;
    logic                             tick_acc;
    logic [IDX_W-1:0]                 load_idx;
    logic [NW-1:0]                    n_eff;
    logic                             issue;

    logic                             rem_we;
    logic [IDX_W-1:0]                 rem_waddr;
    logic [srtf_pkg::DATA_W-1:0]      rem_wdata;
    logic [srtf_pkg::DATA_W-1:0]      rem_rdata;
    logic [AB_W-1:0]                  ab_rdata;
    logic [srtf_pkg::DATA_W-1:0]      rem_eff;

    srtf_pkg::best_t                  best;
    logic [IDX_W-1:0]                 pick;

    logic                             fin;
    logic [srtf_pkg::TIME_W-1:0]      time_new;
    logic [srtf_pkg::TIME_W-1:0]      tat;
    logic [srtf_pkg::TIME_W-1:0]      burst_ext;

    assign accept   = start && !busy;
    assign load_acc = accept && (item.operation == srtf_pkg::OP_LOAD) &&
                      (32'(item.proc_index) < 32'(MAX_PROCS));
    assign tick_acc = accept && (item.operation == srtf_pkg::OP_TICK);
    assign load_idx = IDX_W'(item.proc_index);

    assign n_eff = (NW'(num_procs_reg) > NW'(MAX_PROCS)) ? NW'(MAX_PROCS)
                                                         : NW'(num_procs_reg);
    assign issue = (state_reg == ST_SCAN) && (NW'(scan_cnt_reg) < n_eff);

    // remaining-time write port: load, or writeback of the tick's pick
    always_comb
    begin
        rem_we    = 1'b0;
        rem_waddr = load_idx;
        rem_wdata = item.burst;
        if (load_acc)
        begin
            rem_we = 1'b1;
        end
        else if (state_reg == ST_CALC && best.found)
        begin
            rem_we    = 1'b1;
            rem_waddr = pick;
            rem_wdata = best.rem - 1'b1;
        end
    end

    srtf_ram #(
        .WIDTH(AB_W),
        .DEPTH(MAX_PROCS)
    ) u_ab_ram (
        .clk   (clk),
        .we    (load_acc),
        .waddr (load_idx),
        .wdata ({item.arrival, item.burst}),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (ab_rdata)
    );

    srtf_ram #(
        .WIDTH(srtf_pkg::DATA_W),
        .DEPTH(MAX_PROCS)
    ) u_rem_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (rem_rdata)
    );

    // never-loaded entries read as zero remaining time
    assign rem_eff = rd_valid_reg ? rem_rdata : '0;

    srtf_select #(
        .MAX_PROCS(MAX_PROCS)
    ) u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (tick_acc),
        .eval    ((state_reg == ST_SCAN) && pend_reg),
        .idx     (rd_idx_reg),
        .rem     (rem_eff),
        .arrival (ab_rdata[AB_W-1:srtf_pkg::DATA_W]),
        .burst   (ab_rdata[srtf_pkg::DATA_W-1:0]),
        .now     (time_reg),
        .best    (best),
        .pick    (pick)
    );

    assign fin       = best.found && (best.rem == srtf_pkg::DATA_W'(1));
    assign time_new  = (time_reg == srtf_pkg::TIME_MAX) ? time_reg : time_reg + 1'b1;
    assign tat       = time_new - srtf_pkg::TIME_W'(best.arrival);
    assign burst_ext = srtf_pkg::TIME_W'(best.burst);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            num_procs_reg    <= '0;
            time_reg         <= '0;
            done_cnt_reg     <= '0;
            valid_reg        <= '0;
            scan_cnt_reg     <= '0;
            pend_reg         <= 1'b0;
            rd_idx_reg       <= '0;
            rd_valid_reg     <= 1'b0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                num_procs_reg <= cfg_data;
            end
            if (load_acc)
            begin
                valid_reg[load_idx] <= 1'b1;
            end
            // read data arrives in the cycle after the address
            pend_reg     <= issue;
            rd_idx_reg   <= scan_cnt_reg[IDX_W-1:0];
            rd_valid_reg <= valid_reg[scan_cnt_reg[IDX_W-1:0]];

            case (state_reg)
                ST_IDLE:
                begin
                    scan_cnt_reg <= '0;
                    if (tick_acc)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        // last pending entry is evaluated in this cycle
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    result_reg.tick_time   <= time_reg;
                    result_reg.chosen_proc <= best.found ? 4'(pick) : 4'd0;
                    result_reg.idle        <= !best.found;
                    result_reg.finished    <= fin;
                    result_reg.turnaround  <= fin ? tat : '0;
                    time_reg               <= time_new;
                    if (fin && done_cnt_reg != srtf_pkg::COUNT_MAX)
                    begin
                        done_cnt_reg <= done_cnt_reg + 1'b1;
                    end
                    state_reg <= ST_REPORT;
                end
                ST_REPORT:
                begin
                    if (result_reg.finished && result_reg.turnaround >= burst_ext)
                    begin
                        result_reg.waiting <= result_reg.turnaround - burst_ext;
                    end
                    else
                    begin
                        result_reg.waiting <= '0;
                    end
                    result_reg.all_done <= (NW'(done_cnt_reg) >= n_eff);
                    result_valid_reg    <= 1'b1;
                    state_reg           <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

[sim/srtf_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// srtf_scheduler_tb
// Self-checking bench for the preemptive shortest-remaining-time-first
// scheduler: directed load/tick words, then random phases with varying
// process counts and random start gaps; every tick result is checked field
// by field against an in-bench scheduling predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_scheduler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NPROC     = srtf_pkg::MAX_PROCS_DEF;
    localparam int unsigned WORDS     = 1250;
    localparam int unsigned SETTLE    = NPROC + 10;

    // tracks table, clock and completions; predicts each tick result
    class srtf_scoreboard;
        bit [srtf_pkg::DATA_W-1:0]  arrival_tbl [NPROC];
        bit [srtf_pkg::DATA_W-1:0]  burst_tbl   [NPROC];
        bit [srtf_pkg::DATA_W-1:0]  remain_tbl  [NPROC];
        bit [srtf_pkg::TIME_W-1:0]  now;
        bit [srtf_pkg::CNT_W-1:0]   done_count;
        bit [srtf_pkg::NPROC_W-1:0] num_procs;
        srtf_pkg::result_t          expected_ticks[$];
        int unsigned                failures;

        function int unsigned active_procs();
            return (num_procs > NPROC) ? NPROC : num_procs;
        endfunction

        function void note_accepted(srtf_pkg::item_t w);
            srtf_pkg::result_t         r;
            int unsigned               n;
            int unsigned               pick;
            bit                        found;
            bit [srtf_pkg::DATA_W-1:0] best;
            bit [srtf_pkg::TIME_W-1:0] tat;
            if (w.operation == srtf_pkg::OP_LOAD)
            begin
                arrival_tbl[w.proc_index] = w.arrival;
                burst_tbl[w.proc_index]   = w.burst;
                remain_tbl[w.proc_index]  = w.burst;
                return;
            end
            n     = active_procs();
            r     = '0;
            found = 0;
            pick  = 0;
            best  = '0;
            r.tick_time = now;
            for (int i = 0; i < n; i++)
            begin
                if ({8'd0, arrival_tbl[i]} <= now && remain_tbl[i] != 0 &&
                    (!found || remain_tbl[i] < best))
                begin
                    found = 1;
                    best  = remain_tbl[i];
                    pick  = i;
                end
            end
            if (now != srtf_pkg::TIME_MAX)
                now++;
            if (found)
            begin
                remain_tbl[pick]--;
                if (remain_tbl[pick] == 0)
                begin
                    r.finished = 1'b1;
                    if (done_count != srtf_pkg::COUNT_MAX)
                        done_count++;
                    tat          = now - {8'd0, arrival_tbl[pick]};
                    r.turnaround = tat;
                    r.waiting    = (tat >= {8'd0, burst_tbl[pick]}) ?
                                   tat - {8'd0, burst_tbl[pick]} : '0;
                end
            end
            r.chosen_proc = found ? pick[3:0] : 4'd0;
            r.idle        = !found;
            r.all_done    = (done_count >= n);
            expected_ticks.push_back(r);
        endfunction

        function void field_check(string name, logic [srtf_pkg::TIME_W-1:0] want,
                                  logic [srtf_pkg::TIME_W-1:0] got,
                                  logic [srtf_pkg::TIME_W-1:0] at);
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch at tick_time %0d: %s expected %0h got %0h",
                             at, name, want, got);
            end
        endfunction

        function void check_result(srtf_pkg::result_t got);
            srtf_pkg::result_t want;
            if (expected_ticks.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result word: tick_time %0h proc %0h",
                             got.tick_time, got.chosen_proc);
                return;
            end
            want = expected_ticks.pop_front();
            field_check("tick_time",   want.tick_time,   got.tick_time,   want.tick_time);
            field_check("chosen_proc", srtf_pkg::TIME_W'(want.chosen_proc),
                        srtf_pkg::TIME_W'(got.chosen_proc), want.tick_time);
            field_check("idle",        srtf_pkg::TIME_W'(want.idle),
                        srtf_pkg::TIME_W'(got.idle), want.tick_time);
            field_check("finished",    srtf_pkg::TIME_W'(want.finished),
                        srtf_pkg::TIME_W'(got.finished), want.tick_time);
            field_check("turnaround",  want.turnaround,  got.turnaround,  want.tick_time);
            field_check("waiting",     want.waiting,     got.waiting,     want.tick_time);
            field_check("all_done",    srtf_pkg::TIME_W'(want.all_done),
                        srtf_pkg::TIME_W'(got.all_done), want.tick_time);
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    srtf_pkg::item_t              item;
    srtf_pkg::result_t            result;
    logic                         result_valid;
    logic                         cfg_we;
    logic [srtf_pkg::NPROC_W-1:0] cfg_data;

    srtf_scoreboard sb = new();
    int unsigned    words_sent;
    bit             no_gaps;

    srtf_scheduler #(.MAX_PROCS(NPROC)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    function automatic srtf_pkg::item_t load_word(int unsigned idx, int unsigned arr,
                                                  int unsigned bur);
        srtf_pkg::item_t w;
        w.operation  = srtf_pkg::OP_LOAD;
        w.proc_index = idx[3:0];
        w.arrival    = arr[srtf_pkg::DATA_W-1:0];
        w.burst      = bur[srtf_pkg::DATA_W-1:0];
        return w;
    endfunction

    function automatic srtf_pkg::item_t tick_word();
        srtf_pkg::item_t w;
        w.operation  = srtf_pkg::OP_TICK;
        w.proc_index = 4'($urandom_range(0, 15));
        w.arrival    = srtf_pkg::DATA_W'($urandom_range(0, 65535));
        w.burst      = srtf_pkg::DATA_W'($urandom_range(0, 65535));
        return w;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned gap_len();
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // start stays high after acceptance until the next negedge decides
    task automatic send_word(srtf_pkg::item_t w);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_accepted(w);
        words_sent++;
    endtask

    task automatic quiesce();
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_procs(int unsigned n);
        quiesce();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= n[srtf_pkg::NPROC_W-1:0];
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.num_procs = n[srtf_pkg::NPROC_W-1:0];
    endtask

    initial
    begin
        int unsigned n_eff;
        int unsigned len;
        int unsigned idx;
        int unsigned arr;
        int unsigned bur;
        int unsigned r;

        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        no_gaps  = 1'b0;
        words_sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty schedule, ties, zero burst, extremes, reloads
        send_word(tick_word());
        set_procs(4);
        send_word(load_word(0, 0, 2));
        send_word(load_word(1, 0, 2));
        send_word(load_word(2, 0, 0));
        send_word(load_word(3, 16'hFFFF, 16'hFFFF));
        send_word(load_word(15, 0, 1));
        repeat (5) send_word(tick_word());
        send_word(load_word(0, 0, 1));
        send_word(tick_word());
        // num_procs above the table size covers all entries
        set_procs(31);
        repeat (2) send_word(tick_word());
        set_procs(16);
        send_word(load_word(7, 2, 1));
        send_word(tick_word());
        set_procs(1);
        send_word(load_word(0, 0, 1));
        send_word(tick_word());
        set_procs(0);
        send_word(tick_word());

        // random phases: load a few entries for the active range, then run ticks
        while (words_sent < WORDS)
        begin
            r = $urandom_range(0, 9);
            case (r)
                0: set_procs(0);
                1: set_procs(31);
                2: set_procs(16);
                3: set_procs(1);
                default: set_procs($urandom_range(2, 20));
            endcase
            n_eff   = sb.active_procs();
            no_gaps = ($urandom_range(0, 3) == 0);
            len     = $urandom_range(20, 80);
            repeat (len)
            begin
                if ($urandom_range(0, 99) < 30)
                begin
                    if (n_eff > 0 && $urandom_range(0, 99) < 85)
                        idx = $urandom_range(0, n_eff - 1);
                    else
                        idx = $urandom_range(0, 15);
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        arr = sb.now + $urandom_range(0, 10);
                    else if (r < 90)
                        arr = $urandom_range(0, sb.now);
                    else
                        arr = $urandom_range(0, 65535);
                    if (arr > 65535)
                        arr = 65535;
                    r = $urandom_range(0, 99);
                    if (r < 80)
                        bur = $urandom_range(1, 6);
                    else if (r < 88)
                        bur = 0;
                    else
                        bur = $urandom_range(0, 65535);
                    send_word(load_word(idx, arr, bur));
                end
                else
                begin
                    send_word(tick_word());
                end
            end
        end

        quiesce();
        if (sb.failures == 0 && sb.expected_ticks.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
